FILE: sv/btls_pkg.sv
// Shared types, sizes and codes for the bilinear transmittance table sampler.
// No dependencies; every other file except btls_ram imports this package.
package btls_pkg;

    localparam int MAX_ALT_ROWS = 64;
    localparam int MAX_COS_COLS = 64;
    localparam int CHANNEL_BITS = 16;

    localparam int LUT_DEPTH = MAX_ALT_ROWS * MAX_COS_COLS;
    localparam int ADDR_W    = $clog2(LUT_DEPTH);
    localparam int ENTRY_W   = 3 * CHANNEL_BITS;
    localparam int ROW_W     = $clog2(MAX_ALT_ROWS);
    localparam int COL_W     = $clog2(MAX_COS_COLS);
    localparam int FRAC_W    = 17;  // 0..65536

    // shared multiply-add unit sizes
    localparam int MAC_A_W = (CHANNEL_BITS + 1 > 25) ? CHANNEL_BITS + 1 : 25;
    localparam int MAC_B_W = 18;
    localparam int ACC_W   = 58;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ALT_BINS    = 3'd0;
    localparam t_cfg_idx CFG_COS_BINS    = 3'd1;
    localparam t_cfg_idx CFG_MIN_RADIUS  = 3'd2;
    localparam t_cfg_idx CFG_ALT_SCALE   = 3'd3;
    localparam t_cfg_idx CFG_TABLE_READY = 3'd4;

    localparam logic [6:0]  RST_ALT_BINS   = 7'd64;
    localparam logic [6:0]  RST_COS_BINS   = 7'd64;
    localparam logic [23:0] RST_MIN_RADIUS = 24'd6360000;
    localparam logic [31:0] RST_ALT_SCALE  = 32'd10570;

    typedef struct packed {
        logic [6:0]  alt_rows;
        logic [6:0]  cos_cols;
        logic [23:0] min_radius;
        logic [31:0] altitude_scale;
        logic        table_ready;
    } t_cfg;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        entry_index;
        logic [15:0]        entry_r;
        logic [15:0]        entry_g;
        logic [15:0]        entry_b;
        logic [23:0]        radius;
        logic signed [15:0] zen_cos;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_r;
        logic [15:0] out_g;
        logic [15:0] out_b;
        logic        valid_res;
    } t_out_item;

    typedef struct packed {
        logic                      en;
        logic                      sh16;   // shift product left by 16 before adding
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
        logic signed [ACC_W-1:0]   addend;
    } t_mac_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FA_LO,
        S_FA_HI,
        S_COS,
        S_BASE,
        S_READ,
        S_LERP,
        S_DONE
    } t_state;

endpackage

FILE: sv/btls_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
// Generic; no package dependency.
module btls_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/btls_mac.sv
// Shared signed multiply-add unit with registered result.
// Depends on btls_pkg for operand sizes and the op struct.
module btls_mac (
    input  logic                            i_clk,
    input  btls_pkg::t_mac_op               i_op,
    output logic signed [btls_pkg::ACC_W-1:0] o_res
);
    import btls_pkg::*;

    logic signed [MAC_A_W+MAC_B_W-1:0] prod;
    logic signed [ACC_W-1:0]           prod_ext;
    logic signed [ACC_W-1:0]           r_res;

    always_comb begin
        prod     = i_op.a * i_op.b;
        prod_ext = ACC_W'(prod);
        if (i_op.sh16) begin
            prod_ext = prod_ext <<< 16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_res <= i_op.addend + prod_ext;
        end
    end

    assign o_res = r_res;

endmodule

FILE: sv/btls_core.sv
// Sequencer and datapath: coordinate mapping, four table reads, nine lerps.
// Depends on btls_pkg, btls_mac and btls_ram.
module btls_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  btls_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  btls_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output btls_pkg::t_out_item  o_out_data
);
    import btls_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_ch, n_ch;
    logic [1:0] r_ph, n_ph;

    logic                    r_ok;
    logic [23:0]             r_d;
    logic [15:0]             r_cc;
    logic [6:0]              r_ab;
    logic [6:0]              r_cb;
    logic [ROW_W-1:0]        r_a0;
    logic [COL_W-1:0]        r_c0;
    logic [FRAC_W-1:0]       r_ta;
    logic [FRAC_W-1:0]       r_tc;
    logic [ENTRY_W-1:0]      r_v [4];
    logic [CHANNEL_BITS-1:0] r_lo;
    logic [CHANNEL_BITS-1:0] r_chan0;
    logic [CHANNEL_BITS-1:0] r_chan1;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    t_mac_op                 mac_op;
    logic signed [ACC_W-1:0] mac_res;
    logic [CHANNEL_BITS-1:0] res_chan;

    logic                    in_acc;
    logic                    load_out;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]      mem_rdata;

    // front-end values computed at accept
    logic [6:0]         ab_clamp;
    logic [6:0]         cb_clamp;
    logic [23:0]        d_val;
    logic signed [16:0] c_ext;
    logic [15:0]        cc_val;

    // coordinate split
    logic [ACC_W-1:0]  res_u;
    logic [ACC_W-1:0]  fa_max;
    logic [ACC_W-1:0]  fc_half_max;
    logic              fa_sat;
    logic              fc_sat;

    // lerp operands
    logic [CHANNEL_BITS-1:0]       lx;
    logic [CHANNEL_BITS-1:0]       ly;
    logic [FRAC_W-1:0]             lt;
    logic signed [CHANNEL_BITS:0]  ldiff;

    btls_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_res (mac_res)
    );

    btls_ram #(
        .DEPTH  (LUT_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign res_u    = $unsigned(mac_res);
    assign res_chan = mac_res[16 +: CHANNEL_BITS];

    // table write straight from the accepted item
    assign mem_we    = in_acc && (i_in_data.cmd == CMD_WRITE)
                       && (int'(i_in_data.entry_index) < LUT_DEPTH);
    assign mem_waddr = ADDR_W'(i_in_data.entry_index);
    assign mem_wdata = {CHANNEL_BITS'(i_in_data.entry_b), CHANNEL_BITS'(i_in_data.entry_g),
                        CHANNEL_BITS'(i_in_data.entry_r)};

    always_comb begin
        if (i_cfg.alt_rows < 7'd2) begin
            ab_clamp = 7'd2;
        end else if (int'(i_cfg.alt_rows) > MAX_ALT_ROWS) begin
            ab_clamp = 7'(MAX_ALT_ROWS);
        end else begin
            ab_clamp = i_cfg.alt_rows;
        end
        if (i_cfg.cos_cols < 7'd2) begin
            cb_clamp = 7'd2;
        end else if (int'(i_cfg.cos_cols) > MAX_COS_COLS) begin
            cb_clamp = 7'(MAX_COS_COLS);
        end else begin
            cb_clamp = i_cfg.cos_cols;
        end
        d_val = (i_in_data.radius > i_cfg.min_radius)
                ? i_in_data.radius - i_cfg.min_radius : 24'd0;
        c_ext = 17'(i_in_data.zen_cos) + 17'sd16384;
        if (i_in_data.zen_cos < -16'sd16384) begin
            cc_val = 16'd0;
        end else if (i_in_data.zen_cos > 16'sd16384) begin
            cc_val = 16'd32768;
        end else begin
            cc_val = c_ext[15:0];
        end
    end

    // fa saturates at (ab-1)<<24; fc = 2*res saturates at (cb-1)<<16
    assign fa_max      = ACC_W'(r_ab - 7'd1) << 24;
    assign fc_half_max = ACC_W'(r_cb - 7'd1) << 15;
    assign fa_sat      = res_u >= fa_max;
    assign fc_sat      = res_u >= fc_half_max;

    // lerp operand selection by phase
    always_comb begin
        case (r_ph)
            2'd0: begin
                lx = r_v[0][r_ch*CHANNEL_BITS +: CHANNEL_BITS];
                ly = r_v[1][r_ch*CHANNEL_BITS +: CHANNEL_BITS];
                lt = r_tc;
            end
            2'd1: begin
                lx = r_v[2][r_ch*CHANNEL_BITS +: CHANNEL_BITS];
                ly = r_v[3][r_ch*CHANNEL_BITS +: CHANNEL_BITS];
                lt = r_tc;
            end
            default: begin
                lx = r_lo;
                ly = res_chan;
                lt = r_ta;
            end
        endcase
        ldiff = $signed({1'b0, ly}) - $signed({1'b0, lx});
    end

    // read address: base row offset plus column, second row adds cb
    function automatic logic [ADDR_W-1:0] rd_addr();
        logic [ADDR_W-1:0] row_off;
        row_off = r_cnt[1] ? ADDR_W'(r_cb) : '0;
        rd_addr = res_u[ADDR_W-1:0] + row_off + ADDR_W'(r_c0) + ADDR_W'(r_cnt[0]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ch    <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
            r_ph    <= n_ph;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ch      = r_ch;
        n_ph      = r_ph;
        mac_op    = '0;
        mem_re    = 1'b0;
        mem_raddr = rd_addr();
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.cmd == CMD_SAMPLE)) begin
                    n_state = i_cfg.table_ready ? S_FA_LO : S_DONE;
                end
            end
            S_FA_LO: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_d);
                mac_op.b  = MAC_B_W'(i_cfg.altitude_scale[15:0]);
                n_state   = S_FA_HI;
            end
            S_FA_HI: begin
                mac_op.en     = 1'b1;
                mac_op.sh16   = 1'b1;
                mac_op.a      = MAC_A_W'(r_d);
                mac_op.b      = MAC_B_W'(i_cfg.altitude_scale[31:16]);
                mac_op.addend = mac_res;
                n_state       = S_COS;
            end
            S_COS: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_cc);
                mac_op.b  = MAC_B_W'(r_cb - 7'd1);
                n_state   = S_BASE;
            end
            S_BASE: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_a0);
                mac_op.b  = MAC_B_W'(r_cb);
                n_cnt     = '0;
                n_state   = S_READ;
            end
            S_READ: begin
                mem_re = (r_cnt != 3'd4);
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_ch    = '0;
                    n_ph    = '0;
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                mac_op.en     = 1'b1;
                mac_op.a      = MAC_A_W'(ldiff);
                mac_op.b      = MAC_B_W'(lt);
                mac_op.addend = $signed(ACC_W'(lx) << 16);
                if (r_ph == 2'd2) begin
                    n_ph = '0;
                    n_ch = r_ch + 2'd1;
                    if (r_ch == 2'd2) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ok <= i_cfg.table_ready;
            r_d  <= d_val;
            r_cc <= cc_val;
            r_ab <= ab_clamp;
            r_cb <= cb_clamp;
        end
        if (r_state == S_COS) begin
            r_a0 <= fa_sat ? ROW_W'(r_ab - 7'd2) : res_u[24 +: ROW_W];
            r_ta <= fa_sat ? FRAC_W'(65536) : {1'b0, res_u[23:8]};
        end
        if (r_state == S_BASE) begin
            r_c0 <= fc_sat ? COL_W'(r_cb - 7'd2) : res_u[15 +: COL_W];
            r_tc <= fc_sat ? FRAC_W'(65536) : {1'b0, res_u[14:0], 1'b0};
        end
        if ((r_state == S_READ) && (r_cnt != 3'd0)) begin
            r_v[r_cnt[1:0] - 2'd1] <= mem_rdata;
        end
        if (r_state == S_LERP) begin
            if (r_ph == 2'd1) begin
                r_lo <= res_chan;
            end
            if ((r_ph == 2'd0) && (r_ch == 2'd1)) begin
                r_chan0 <= res_chan;
            end
            if ((r_ph == 2'd0) && (r_ch == 2'd2)) begin
                r_chan1 <= res_chan;
            end
        end
        if (load_out) begin
            if (r_ok) begin
                r_out_data.out_r     <= 16'(r_chan0);
                r_out_data.out_g     <= 16'(r_chan1);
                r_out_data.out_b     <= 16'(res_chan);
                r_out_data.valid_res <= 1'b1;
            end else begin
                r_out_data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/bilinear_transmittance_lut_sampler_top.sv
// A sample steps through FA_LO, FA_HI, COS, BASE, the table reads, the lerps and DONE; a write
// leaves the sequencer idle, and a sample while the table is not ready goes straight to DONE.
// Samples run one at a time on the shared multiplier (4 mapping products, 9 lerps) and read port.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) clears the sequencer, output valid and table_ready and loads
// config defaults; table contents are not cleared and must be written before they are sampled.
module bilinear_transmittance_lut_sampler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  btls_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output btls_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  btls_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import btls_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alt_rows       <= RST_ALT_BINS;
            r_cfg.cos_cols       <= RST_COS_BINS;
            r_cfg.min_radius     <= RST_MIN_RADIUS;
            r_cfg.altitude_scale <= RST_ALT_SCALE;
            r_cfg.table_ready    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALT_BINS:    r_cfg.alt_rows       <= i_cfg_data[6:0];
                CFG_COS_BINS:    r_cfg.cos_cols       <= i_cfg_data[6:0];
                CFG_MIN_RADIUS:  r_cfg.min_radius     <= i_cfg_data[23:0];
                CFG_ALT_SCALE:   r_cfg.altitude_scale <= i_cfg_data;
                CFG_TABLE_READY: r_cfg.table_ready    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    btls_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_res ||
            (o_out_data.out_r == 16'd0 && o_out_data.out_g == 16'd0 &&
             o_out_data.out_b == 16'd0)))
        else $error("result without table data carries nonzero channels");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.cmd == CMD_SAMPLE) |=> !o_in_ready)
        else $error("sample item did not occupy the sequencer");

    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.cmd == CMD_WRITE) |=> o_in_ready)
        else $error("write item stalled the input");
`endif

endmodule

FILE: tb/sv/bilinear_transmittance_lut_sampler_top_test.sv
// Self-checking testbench for bilinear_transmittance_lut_sampler_top: table loads, config
// sweeps and interpolated samples checked against an in-bench fixed-point predictor.
// Depends on btls_pkg and the sampler RTL only.
module bilinear_transmittance_lut_sampler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import btls_pkg::*;

    // the fill loads only the low entries; every sampling config keeps rows*cols within them
    localparam int FILL_DEPTH = 256;

    // Mirrors the table and config registers; predicts one result per sample item.
    class transmittance_checker;
        logic [6:0]  alt_rows       = RST_ALT_BINS;
        logic [6:0]  cos_cols       = RST_COS_BINS;
        logic [23:0] min_radius     = RST_MIN_RADIUS;
        logic [31:0] altitude_scale = RST_ALT_SCALE;
        logic        table_ready    = 1'b0;
        logic [15:0] lut [LUT_DEPTH][3];
        t_out_item   pending_samples [$];
        int          errors = 0;

        static function int eff_bins(int n, int top);
            return (n < 2) ? 2 : (n > top) ? top : n;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_ALT_BINS:    alt_rows = val[6:0];
                CFG_COS_BINS:    cos_cols = val[6:0];
                CFG_MIN_RADIUS:  min_radius = val[23:0];
                CFG_ALT_SCALE:   altitude_scale = val;
                CFG_TABLE_READY: table_ready = val[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] lerp(logic [63:0] x, logic [63:0] y, logic [63:0] t);
            return (x * (64'd65536 - t) + y * t) >> 16;
        endfunction

        function t_out_item blend_sample(t_in_item item);
            t_out_item   res;
            int          ab, cb, a0, c0, c;
            logic [63:0] d, fa, fa_max, fc, ta, tc, lo, hi;
            logic [15:0] blended [3];
            res = '0;
            if (!table_ready) return res;
            ab = eff_bins(alt_rows, MAX_ALT_ROWS);
            cb = eff_bins(cos_cols, MAX_COS_COLS);
            d = (item.radius > min_radius) ? 64'(item.radius - min_radius) : 64'd0;
            fa = d * 64'(altitude_scale);
            fa_max = 64'(ab - 1) << 24;
            if (fa > fa_max) fa = fa_max;
            a0 = int'(fa >> 24);
            if (a0 > ab - 2) a0 = ab - 2;
            ta = (fa - (64'(a0) << 24)) >> 8;
            c = int'($signed(item.zen_cos));
            if (c < -16384) c = -16384;
            if (c > 16384) c = 16384;
            fc = 64'(c + 16384) * 64'(cb - 1) * 64'd2;
            c0 = int'(fc >> 16);
            if (c0 > cb - 2) c0 = cb - 2;
            tc = fc - (64'(c0) << 16);
            for (int ch = 0; ch < 3; ch++) begin
                lo = lerp(lut[a0 * cb + c0][ch], lut[a0 * cb + c0 + 1][ch], tc);
                hi = lerp(lut[(a0 + 1) * cb + c0][ch], lut[(a0 + 1) * cb + c0 + 1][ch], tc);
                blended[ch] = 16'(lerp(lo, hi, ta));
            end
            res.out_r = blended[0];
            res.out_g = blended[1];
            res.out_b = blended[2];
            res.valid_res = 1'b1;
            return res;
        endfunction

        function void note_item(t_in_item item);
            if (item.cmd == CMD_WRITE) begin
                lut[item.entry_index][0] = item.entry_r;
                lut[item.entry_index][1] = item.entry_g;
                lut[item.entry_index][2] = item.entry_b;
            end else begin
                pending_samples.push_back(blend_sample(item));
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_sample(t_out_item got);
            t_out_item want;
            if (pending_samples.size() == 0) begin
                flag($sformatf("unexpected result: r=%h g=%h b=%h v=%b",
                               got.out_r, got.out_g, got.out_b, got.valid_res));
                return;
            end
            want = pending_samples.pop_front();
            if (got.out_r !== want.out_r || got.out_g !== want.out_g ||
                got.out_b !== want.out_b || got.valid_res !== want.valid_res)
                flag($sformatf("sample mismatch: want r=%h g=%h b=%h v=%b, got r=%h g=%h b=%h v=%b",
                               want.out_r, want.out_g, want.out_b, want.valid_res,
                               got.out_r, got.out_g, got.out_b, got.valid_res));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    t_cfg_idx    cfg_index = CFG_ALT_BINS;
    logic [31:0] cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    t_out_item   o_out_data;

    transmittance_checker chk = new;
    int     send_idle_pct = 11;
    int     recv_idle_pct = 67;
    longint focus_lo = 0;
    longint focus_hi = 24'hFFFFFF;

    bilinear_transmittance_lut_sampler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) chk.check_sample(o_out_data);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_in_item make_write(logic [11:0] idx, logic [15:0] r, logic [15:0] g,
                                            logic [15:0] b);
        t_in_item it;
        it.cmd = CMD_WRITE;
        it.entry_index = idx;
        it.entry_r = r;
        it.entry_g = g;
        it.entry_b = b;
        it.radius = 24'($urandom);
        it.zen_cos = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_sample(logic [23:0] rad, logic [15:0] cosz);
        t_in_item it;
        it.cmd = CMD_SAMPLE;
        it.entry_index = 12'($urandom);
        it.entry_r = 16'($urandom);
        it.entry_g = 16'($urandom);
        it.entry_b = 16'($urandom);
        it.radius = rad;
        it.zen_cos = cosz;
        return it;
    endfunction

    function automatic logic [31:0] scale_for(logic [6:0] ab, longint span);
        return 32'((longint'(chk.eff_bins(ab, MAX_ALT_ROWS) - 1) << 24) / span);
    endfunction

    function automatic logic [23:0] random_radius();
        if ($urandom_range(99) < 75) return 24'($urandom_range(focus_hi, focus_lo));
        return 24'($urandom);
    endfunction

    function automatic logic [15:0] random_cos();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'(-16384);
                2: return 16'd0;
                3: return 16'd16384;
                default: return 16'h7FFF;
            endcase
        end
        if (pick < 30) return 16'($urandom);
        return 16'($signed($urandom_range(34000)) - 17000);
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        chk.note_item(item);
    endtask

    // drain: hold input, wait out every expected sample, then let trailing writes land
    task automatic settle();
        in_valid <= 1'b0;
        while (chk.pending_samples.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.set_reg(idx, val);
    endtask

    task automatic apply_config(input logic [6:0] ab, input logic [6:0] cb,
                                input logic [23:0] minr, input logic [31:0] scale,
                                input logic ready, input bit poke_unused);
        longint span;
        settle();
        if (poke_unused)
            for (int i = int'(CFG_TABLE_READY) + 1; i < 8; i++) write_reg(t_cfg_idx'(i), $urandom);
        // upper data bits are junk on purpose, registers keep only their width
        write_reg(CFG_ALT_BINS, {25'($urandom), ab});
        write_reg(CFG_COS_BINS, {25'($urandom), cb});
        write_reg(CFG_MIN_RADIUS, {8'($urandom), minr});
        write_reg(CFG_ALT_SCALE, scale);
        write_reg(CFG_TABLE_READY, {31'($urandom), ready});
        cfg_valid <= 1'b0;
        // aim most radii at the span the table covers, a bit beyond on both sides
        span = (scale == 0) ? 64'd1000000
             : (longint'(chk.eff_bins(ab, MAX_ALT_ROWS) - 1) << 24) / scale;
        if (span < 8) span = 8;
        focus_lo = longint'(minr) - span / 8;
        focus_hi = longint'(minr) + span + span / 8;
        if (focus_lo < 0) focus_lo = 0;
        if (focus_hi > 24'hFFFFFF) focus_hi = 24'hFFFFFF;
        if (focus_lo > focus_hi) focus_lo = focus_hi;
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 15)
                send_item(make_write(12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
            else
                send_item(make_sample(random_radius(), random_cos()));
        end
    endtask

    initial begin
        logic [6:0] ab, cb;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // table not ready yet: samples come back zero with valid clear
        send_item(make_sample(24'd0, 16'h8000));
        send_item(make_sample(24'hFFFFFF, 16'h7FFF));
        send_item(make_write(12'd0, 16'hFFFF, 16'h0000, 16'h8000));
        send_item(make_sample(RST_MIN_RADIUS, 16'd0));

        for (int i = 0; i < FILL_DEPTH; i++)
            send_item(make_write(12'(i), 16'($urandom), 16'($urandom), 16'($urandom)));

        apply_config(RST_ALT_BINS, 7'd4, RST_MIN_RADIUS, RST_ALT_SCALE, 1'b1, 1'b1);
        send_item(make_write(12'd0, 16'hFFFF, 16'h0000, 16'h8000));
        send_item(make_sample(24'd0, 16'h8000));
        send_item(make_write(12'd255, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_item(make_sample(24'hFFFFFF, 16'h7FFF));
        send_item(make_sample(RST_MIN_RADIUS - 24'd1, 16'(-16384)));
        send_item(make_sample(RST_MIN_RADIUS, 16'd0));
        send_item(make_sample(RST_MIN_RADIUS + 24'd1, 16'd16383));
        send_item(make_sample(RST_MIN_RADIUS + 24'd50000, 16'd8192));
        send_item(make_sample(RST_MIN_RADIUS + 24'd99996, 16'(-16383)));
        send_item(make_sample(RST_MIN_RADIUS + 24'd100000, 16'd16384));
        send_item(make_sample(RST_MIN_RADIUS + 24'd40000, 16'hFFFF));
        run_random(160);

        apply_config(7'd2, 7'd2, 24'd0, scale_for(7'd2, 5000), 1'b1, 1'b0);
        run_random(160);

        send_idle_pct = 67;
        recv_idle_pct = 11;
        apply_config(7'd127, 7'd0, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        run_random(120);
        apply_config(7'd1, 7'd127, 24'($urandom), 32'd0, 1'b1, 1'b0);
        run_random(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        ab = 7'($urandom_range(64, 2));
        cb = 7'($urandom_range((ab <= 7'd4) ? 64 : FILL_DEPTH / int'(ab), 2));
        apply_config(ab, cb, 24'($urandom), scale_for(ab, $urandom_range(3000000, 1000)),
                     1'b1, 1'b0);
        run_random(160);
        apply_config(7'($urandom), 7'($urandom), 24'($urandom), $urandom, 1'b0, 1'b0);
        run_random(30);
        ab = 7'($urandom_range(64, 2));
        cb = 7'($urandom_range((ab <= 7'd4) ? 64 : FILL_DEPTH / int'(ab), 2));
        apply_config(ab, cb, 24'($urandom), scale_for(ab, $urandom_range(3000000, 1000)),
                     1'b1, 1'b0);
        run_random(200);

        settle();
        if (chk.errors == 0 && chk.pending_samples.size() == 0)
            $display("bilinear_transmittance_lut_sampler_top_test: done, clean");
        else
            $display("bilinear_transmittance_lut_sampler_top_test: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("bilinear_transmittance_lut_sampler_top_test: done, errors");
        $finish;
    end

endmodule
